// ----- hw/rtl/osps_pkg.sv -----
// ----------------------------------------------------------------------------
// osps_pkg: shared definitions for the stepper pattern sequencer
// Widths, register indexes, reset values, coil codes and the small
// phase helpers used by the sequencer core and its side units.
// ----------------------------------------------------------------------------
package osps_pkg;

  // field and state widths
  localparam int STEP_W     = 10;
  localparam int PAT_W      = 4;
  localparam int STROKE_W   = 6;
  localparam int PHASE_W    = 2;
  localparam int COIL_W     = 4;
  localparam int NUM_MOTORS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_STEPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 2'd1;

  // reset values of the configuration registers
  localparam logic [STEP_W-1:0] STROKE_STEPS_RST  = 10'd20;
  localparam logic [PAT_W-1:0]  PATTERN_COUNT_RST = 4'd3;

  // step counters saturate here
  localparam logic [STEP_W-1:0] STEP_MAX = 10'd1023;

  // full-step double-coil codes, bits B-,B+,A-,A+
  localparam logic [COIL_W-1:0] COIL_PH0 = 4'h5;
  localparam logic [COIL_W-1:0] COIL_PH1 = 4'h6;
  localparam logic [COIL_W-1:0] COIL_PH2 = 4'ha;
  localparam logic [COIL_W-1:0] COIL_PH3 = 4'h9;

  // one side of the machine: direction, step count and stroke-done flag
  typedef struct packed {
    logic              dir;
    logic [STEP_W-1:0] steps;
    logic              done;
  } osps_side_t;

  // one result item
  typedef struct packed {
    logic [COIL_W-1:0] coil_motor1;
    logic [COIL_W-1:0] coil_motor2;
    logic [COIL_W-1:0] coil_motor3;
    logic [COIL_W-1:0] coil_motor4;
    logic              stepped;
    logic [PAT_W-1:0]  pattern_number;
  } osps_res_t;

  // phase index to coil code
  function automatic logic [COIL_W-1:0] coil_code(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] code;
    unique case (ph)
      2'd0:    code = COIL_PH0;
      2'd1:    code = COIL_PH1;
      2'd2:    code = COIL_PH2;
      default: code = COIL_PH3;
    endcase
    return code;
  endfunction

  // advance or retreat one phase, wrapping modulo four
  function automatic logic [PHASE_W-1:0] phase_move(input logic [PHASE_W-1:0] ph,
                                                    input logic fwd);
    return fwd ? PHASE_W'(ph + 2'd1) : PHASE_W'(ph - 2'd1);
  endfunction

endpackage

// ----- hw/rtl/osps_if.sv -----
// ----------------------------------------------------------------------------
// osps_if: valid/ready channels of the stepper pattern sequencer
// Request channel carries the timer flag; result channel carries the four
// coil codes, the step flag and the current pattern number.
// ----------------------------------------------------------------------------
interface osps_in_if import osps_pkg::*; ();
  logic valid;
  logic ready;
  logic timer_elapsed;

  modport source (output valid, output timer_elapsed, input ready);
  modport sink   (input valid, input timer_elapsed, output ready);
endinterface

interface osps_out_if import osps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_motor1;
  logic [COIL_W-1:0] coil_motor2;
  logic [COIL_W-1:0] coil_motor3;
  logic [COIL_W-1:0] coil_motor4;
  logic              stepped;
  logic [PAT_W-1:0]  pattern_number;

  modport source (output valid, output coil_motor1, output coil_motor2,
                  output coil_motor3, output coil_motor4, output stepped,
                  output pattern_number, input ready);
  modport sink   (input valid, input coil_motor1, input coil_motor2,
                  input coil_motor3, input coil_motor4, input stepped,
                  input pattern_number, output ready);
endinterface

// ----- hw/rtl/osps_side.sv -----
// ----------------------------------------------------------------------------
// osps_side: step logic of one side (two motors turning in opposite senses)
// Optionally clears the side for a new stroke, then optionally takes one
// step: moves both phases, counts the step and reverses at stroke end.
// ----------------------------------------------------------------------------
module osps_side import osps_pkg::*; (
  input  osps_side_t         side_i,
  input  logic [PHASE_W-1:0] ph_a_i,
  input  logic [PHASE_W-1:0] ph_b_i,
  input  logic               clear,
  input  logic               step,
  input  logic [STEP_W-1:0]  stroke_steps,
  output osps_side_t         side_o,
  output logic [PHASE_W-1:0] ph_a_o,
  output logic [PHASE_W-1:0] ph_b_o
);

  osps_side_t        base;
  logic [STEP_W-1:0] cnt;

  always_comb begin
    // stroke restart clears counter and done flag
    base = side_i;
    if (clear) begin
      base.steps = '0;
      base.done  = 1'b0;
    end

    side_o = base;
    ph_a_o = ph_a_i;
    ph_b_o = ph_b_i;
    cnt    = (base.steps == STEP_MAX) ? base.steps : STEP_W'(base.steps + 1'b1);

    // one step: motor A follows dir, motor B runs the other way
    if (step) begin
      ph_a_o       = phase_move(ph_a_i, base.dir);
      ph_b_o       = phase_move(ph_b_i, ~base.dir);
      side_o.steps = cnt;
      if (cnt < stroke_steps) begin
        side_o.done = 1'b0;
      end else begin
        side_o.done = 1'b1;
        side_o.dir  = ~base.dir;
      end
    end
  end

endmodule

// ----- hw/rtl/osps_seq.sv -----
// ----------------------------------------------------------------------------
// osps_seq: pattern/stroke sequencer state and per-request update
// Holds pattern index, stroke count, motor phases and both side states.
// Computes the next state and the result for one request.
// ----------------------------------------------------------------------------
module osps_seq import osps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              tick,
  input  logic [STEP_W-1:0] stroke_steps,
  input  logic [PAT_W-1:0]  pattern_count,
  output osps_res_t         res
);

  logic [PAT_W-1:0]                     pattern_index_r, pattern_index_nxt;
  logic [STROKE_W-1:0]                  strokes_left_r, strokes_left_nxt;
  logic [NUM_MOTORS-1:0][PHASE_W-1:0]   phase_r, phase_nxt;
  osps_side_t                           left_r, left_nxt, right_r, right_nxt;

  logic                                 clear, step;
  osps_side_t                           left_o, right_o;
  logic [NUM_MOTORS-1:0][PHASE_W-1:0]   phase_o;

  // side units: motors 1/2 on the left, 3/4 on the right
  osps_side u_left (
    .side_i       (left_r),
    .ph_a_i       (phase_r[0]),
    .ph_b_i       (phase_r[1]),
    .clear        (clear),
    .step         (step),
    .stroke_steps (stroke_steps),
    .side_o       (left_o),
    .ph_a_o       (phase_o[0]),
    .ph_b_o       (phase_o[1])
  );

  osps_side u_right (
    .side_i       (right_r),
    .ph_a_i       (phase_r[2]),
    .ph_b_i       (phase_r[3]),
    .clear        (clear),
    .step         (step),
    .stroke_steps (stroke_steps),
    .side_o       (right_o),
    .ph_a_o       (phase_o[2]),
    .ph_b_o       (phase_o[3])
  );

  // sequencing: wrap pattern, load strokes, or run the stroke
  always_comb begin
    pattern_index_nxt = pattern_index_r;
    strokes_left_nxt  = strokes_left_r;
    phase_nxt         = phase_r;
    left_nxt          = left_r;
    right_nxt         = right_r;
    clear             = 1'b0;
    step              = 1'b0;

    if (pattern_index_r < pattern_count) begin
      if (strokes_left_r != '0) begin
        clear            = left_r.done & right_r.done;
        step             = tick;
        strokes_left_nxt = STROKE_W'(strokes_left_r - {{(STROKE_W-1){1'b0}}, clear});
        left_nxt         = left_o;
        right_nxt        = right_o;
        phase_nxt        = phase_o;
      end else begin
        // 2*(p+1)+1 strokes for pattern p
        strokes_left_nxt  = STROKE_W'({pattern_index_r, 1'b0}) + STROKE_W'(3);
        pattern_index_nxt = PAT_W'(pattern_index_r + 1'b1);
        left_nxt.dir      = 1'b1;
        right_nxt.dir     = 1'b1;
      end
    end else begin
      pattern_index_nxt = '0;
    end
  end

  // result fields show the state after the update
  always_comb begin
    res.coil_motor1    = coil_code(phase_nxt[0]);
    res.coil_motor2    = coil_code(phase_nxt[1]);
    res.coil_motor3    = coil_code(phase_nxt[2]);
    res.coil_motor4    = coil_code(phase_nxt[3]);
    res.stepped        = step;
    res.pattern_number = pattern_index_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_index_r <= '0;
      strokes_left_r  <= '0;
      phase_r         <= '0;
      left_r          <= '{dir: 1'b1, steps: '0, done: 1'b0};
      right_r         <= '{dir: 1'b1, steps: '0, done: 1'b0};
    end else if (upd) begin
      pattern_index_r <= pattern_index_nxt;
      strokes_left_r  <= strokes_left_nxt;
      phase_r         <= phase_nxt;
      left_r          <= left_nxt;
      right_r         <= right_nxt;
    end
  end

`ifndef SYNTHESIS
  // no timer tick, no motion
  a_no_tick_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && !tick) |=> $stable(phase_r))
    else $error("phases moved without a timer tick");

  // stroke count never exceeds the largest load (31)
  a_strokes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !strokes_left_r[STROKE_W-1])
    else $error("stroke count out of range");

  // sequencing state only changes on an update
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable({pattern_index_r, strokes_left_r, left_r, right_r}))
    else $error("sequencer state changed without a request");
`endif

endmodule

// ----- hw/rtl/oscillating_stepper_pattern_sequencer.sv -----
// ----------------------------------------------------------------------------
// oscillating_stepper_pattern_sequencer: four-motor full-step pattern driver
// Each request is one scheduler tick; each result gives the four coil codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : valid/ready request channel, one bit timer_elapsed per tick.
//   out_res : valid/ready result channel, exactly one result per request:
//             coil codes of motors 1..4, stepped flag, pattern number.
//   cfg_*   : write port; index 0 = stroke_steps, 1 = pattern_count.
//             Other indexes are ignored. Write only while the block is idle.
// Pipeline: two register stages, request register then result register.
// Throughput: one request per cycle while the result register is not stalled.
//   The whole state update is a single combinational pass between the
//   request register and the result register.
// Reset (rst_n low, synchronous): pattern 0, no strokes loaded, all motors at
//   phase 0 (code 0x5), both sides forward, registers at 20 and 3.
// Stall: when out_res.ready is low the result holds; one more request is
//   buffered in the request register, then in_req.ready drops.
// ----------------------------------------------------------------------------
module oscillating_stepper_pattern_sequencer import osps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  osps_in_if.sink               in_req,
  osps_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              s1_v_r, s1_tick_r;
  logic              out_v_r;
  osps_res_t         res_r, res_nxt;
  logic [STEP_W-1:0] stroke_steps_r;
  logic [PAT_W-1:0]  pattern_count_r;
  logic              advance, upd, in_acc;

  // pipeline control
  assign advance      = !out_v_r || out_res.ready;
  assign upd          = s1_v_r && advance;
  assign in_req.ready = !s1_v_r || advance;
  assign in_acc       = in_req.valid && in_req.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_steps_r  <= STROKE_STEPS_RST;
      pattern_count_r <= PATTERN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STROKE_STEPS:  stroke_steps_r  <= cfg_wdata[STEP_W-1:0];
        CFG_PATTERN_COUNT: pattern_count_r <= cfg_wdata[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tick_r <= in_req.timer_elapsed;
    end
  end

  // sequencer core
  osps_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (upd),
    .tick          (s1_tick_r),
    .stroke_steps  (stroke_steps_r),
    .pattern_count (pattern_count_r),
    .res           (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid          = out_v_r;
  assign out_res.coil_motor1    = res_r.coil_motor1;
  assign out_res.coil_motor2    = res_r.coil_motor2;
  assign out_res.coil_motor3    = res_r.coil_motor3;
  assign out_res.coil_motor4    = res_r.coil_motor4;
  assign out_res.stepped        = res_r.stepped;
  assign out_res.pattern_number = res_r.pattern_number;

`ifndef SYNTHESIS
  // an empty result register never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_req.ready)
    else $error("request blocked with empty result register");

  // every processed request shows up as a result next cycle
  a_upd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_v_r)
    else $error("processed request produced no result");

  // a stepped result always comes from a tick
  a_step_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> (!res_r.stepped || $past(s1_tick_r)))
    else $error("step reported without a timer tick");
`endif

endmodule
